// ----- rtl/core/apct_pkg.sv -----
`timescale 1ns / 1ps
package apct_pkg;

   localparam int COORD_BITS = 20;
   localparam int ID_BITS = 32;
   localparam int KEY_BITS = 2 * ID_BITS;
   localparam int PAIR_SLOTS_DEFAULT = 256;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_ENTER = 2'd1;
   localparam logic [1:0] EV_STAY  = 2'd2;
   localparam logic [1:0] EV_EXIT  = 2'd3;

   typedef struct packed {
      logic [ID_BITS-1:0]           left_id;
      logic [ID_BITS-1:0]           right_id;
      logic signed [COORD_BITS-1:0] left_x;
      logic signed [COORD_BITS-1:0] left_y;
      logic signed [COORD_BITS-1:0] left_w;
      logic signed [COORD_BITS-1:0] left_h;
      logic signed [COORD_BITS-1:0] right_x;
      logic signed [COORD_BITS-1:0] right_y;
      logic signed [COORD_BITS-1:0] right_w;
      logic signed [COORD_BITS-1:0] right_h;
      logic                         left_active;
      logic                         right_active;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] contact_event;
      logic       boxes_overlap;
      logic       table_overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

// ----- rtl/core/apct_if.sv -----
`timescale 1ns / 1ps
interface apct_req_if;
   logic                     valid;
   logic                     ready;
   apct_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface apct_rsp_if;
   logic                     valid;
   logic                     ready;
   apct_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/apct_ram.sv -----
`timescale 1ns / 1ps
module apct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/apct_ctrl.sv -----
`timescale 1ns / 1ps
module apct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  apct_pkg::status_type status,
   output apct_pkg::cmd_type    cmd
);
   import apct_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;
   localparam logic [1:0] S_OUT    = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.commit = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_from_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_SCAN) else $error("load did not start a scan");
   a_commit_then_out: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid) else $error("commit not followed by a result");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
endmodule

// ----- rtl/core/apct_dpath.sv -----
`timescale 1ns / 1ps
module apct_dpath #(
   parameter int PAIR_SLOTS = apct_pkg::PAIR_SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  apct_pkg::cmd_type         cmd,
   output apct_pkg::status_type      status,
   input  apct_pkg::req_payload_type req_payload,
   output apct_pkg::rsp_payload_type rsp_payload
);
   import apct_pkg::*;

   localparam int AW = $clog2(PAIR_SLOTS);
   localparam int CW = $clog2(PAIR_SLOTS + 1);
   localparam int SW = COORD_BITS + 2;
   localparam logic [CW-1:0] FULL = CW'(PAIR_SLOTS);

   req_payload_type item_ff;
   rsp_payload_type result_ff;
   logic [CW-1:0]   used_ff;
   logic [CW-1:0]   idx_ff;
   logic            pend_ff;
   logic            found_ff;
   logic            touch_ff;
   logic [AW-1:0]   slot_ff;

   logic [KEY_BITS-1:0] key;
   logic [KEY_BITS:0]   rd_word;
   logic                hit;
   logic                done;
   logic                rd_en;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic                new_touch;
   logic                insert;
   logic                overflow;
   logic                touching;
   logic                overlap;
   logic                active;
   logic [1:0]          event_code;

   // One axis: 2*|rc-lc| <= |ls+rs|, carried two bits wider than a coordinate.
   function automatic logic axis_ok(logic signed [COORD_BITS-1:0] lc,
                                    logic signed [COORD_BITS-1:0] ls,
                                    logic signed [COORD_BITS-1:0] rc,
                                    logic signed [COORD_BITS-1:0] rs);
      logic signed [SW-1:0] d;
      logic signed [SW-1:0] s;
      logic [SW-1:0]        da;
      logic [SW-1:0]        sa;
      d = SW'(rc) - SW'(lc);
      s = SW'(ls) + SW'(rs);
      da = d[SW-1] ? SW'(-d) : SW'(d);
      sa = s[SW-1] ? SW'(-s) : SW'(s);
      return {da[SW-2:0], 1'b0} <= sa;
   endfunction

   assign key = {item_ff.left_id, item_ff.right_id};
   assign hit = pend_ff && (rd_word[KEY_BITS:1] == key);
   assign done = hit || (!pend_ff && (idx_ff == used_ff));
   assign status.scan_done = done;
   assign rd_en = cmd.step && !done && (idx_ff < used_ff);

   assign overlap = axis_ok(item_ff.left_x, item_ff.left_w, item_ff.right_x, item_ff.right_w)
                 && axis_ok(item_ff.left_y, item_ff.left_h, item_ff.right_y, item_ff.right_h);
   assign active = item_ff.left_active && item_ff.right_active;
   assign insert = !found_ff && (used_ff < FULL);
   assign overflow = !found_ff && !insert;
   assign touching = found_ff && touch_ff;

   always_comb begin
      new_touch = touching;
      if (overlap && active) begin
         if (touching) begin
            event_code = EV_STAY;
         end else begin
            event_code = EV_ENTER;
            new_touch = 1'b1;
         end
      end else if (touching) begin
         event_code = EV_EXIT;
         new_touch = 1'b0;
      end else begin
         event_code = EV_NONE;
      end
   end

   assign wr_en = cmd.commit && (found_ff || insert);
   assign wr_addr = found_ff ? slot_ff : used_ff[AW-1:0];

   apct_ram #(.WIDTH(KEY_BITS + 1), .DEPTH(PAIR_SLOTS)) u_pairs (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data({key, new_touch}),
      .rd_en  (rd_en),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_word)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_payload;
      end
      if (cmd.step && done) begin
         found_ff <= hit;
         touch_ff <= rd_word[0];
         slot_ff <= AW'(idx_ff - CW'(1));
      end
      if (cmd.commit) begin
         result_ff.contact_event <= event_code;
         result_ff.boxes_overlap <= overlap;
         result_ff.table_overflow <= overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         idx_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff <= '0;
            pend_ff <= 1'b0;
         end else if (cmd.step) begin
            pend_ff <= rd_en;
            if (rd_en) begin
               idx_ff <= idx_ff + CW'(1);
            end
         end
         if (cmd.commit && insert) begin
            used_ff <= used_ff + CW'(1);
         end
      end
   end

   assign rsp_payload = result_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= FULL) else $error("fill count beyond table size");
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && overflow |-> used_ff == FULL) else $error("overflow with free slots");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= used_ff) else $error("scan ran past filled entries");
endmodule

// ----- rtl/core/aabb_pair_contact_tracker_top.sv -----
`timescale 1ns / 1ps
// A request beat is loaded, then the scan state reads the pair table RAM in a linear
// key scan, one read a cycle, until a key hit or the end of the stored pairs; the
// decide state commits the table write and the result, held until taken. Throughput:
// one item at a time; the next request beat is taken in the cycle after the response
// beat at the earliest. Reset clears the controller, the fill count and the scan state;
// table contents are reached only below the fill count, so no clearing pass.
module aabb_pair_contact_tracker_top #(
   parameter int PAIR_SLOTS = apct_pkg::PAIR_SLOTS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   apct_req_if.sink   req_ch,
   apct_rsp_if.source rsp_ch
);
   import apct_pkg::*;

   cmd_type    cmd;
   status_type status;

   apct_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .status   (status),
      .cmd      (cmd)
   );

   apct_dpath #(.PAIR_SLOTS(PAIR_SLOTS)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_payload(req_ch.payload),
      .rsp_payload(rsp_ch.payload)
   );
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import apct_pkg::*;

   localparam int SLOTS = PAIR_SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   apct_req_if req_ch ();
   apct_rsp_if rsp_ch ();

   aabb_pair_contact_tracker_top dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: the pair table as the block should hold it.
   logic [KEY_BITS-1:0] pair_key_mem [SLOTS];
   logic pair_touch_mem [SLOTS];
   int pairs_stored;

   req_payload_type pending_checks[$];
   rsp_payload_type expected_contacts[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit stimulus_done = 0;
   bit calm_phase = 0;

   function automatic bit axis_overlaps(logic signed [COORD_BITS-1:0] lc,
                                        logic signed [COORD_BITS-1:0] ls,
                                        logic signed [COORD_BITS-1:0] rc,
                                        logic signed [COORD_BITS-1:0] rs);
      longint d, s;
      d = longint'(rc) - longint'(lc);
      s = longint'(ls) + longint'(rs);
      if (d < 0) d = -d;
      if (s < 0) s = -s;
      return 2 * d <= s;
   endfunction

   function automatic rsp_payload_type track_contact(req_payload_type p);
      rsp_payload_type r;
      logic [KEY_BITS-1:0] key;
      bit found, touching;
      int slot;
      key = {p.left_id, p.right_id};
      found = 0;
      slot = 0;
      r = '0;
      for (int i = 0; i < pairs_stored; i++) begin
         if (!found && pair_key_mem[i] == key) begin
            found = 1;
            slot = i;
         end
      end
      if (!found) begin
         if (pairs_stored < SLOTS) begin
            slot = pairs_stored;
            pair_key_mem[slot] = key;
            pair_touch_mem[slot] = 0;
            pairs_stored++;
            found = 1;
         end else begin
            r.table_overflow = 1'b1;
         end
      end
      touching = found && pair_touch_mem[slot];
      r.boxes_overlap = axis_overlaps(p.left_x, p.left_w, p.right_x, p.right_w) &&
                        axis_overlaps(p.left_y, p.left_h, p.right_y, p.right_h);
      if (r.boxes_overlap && p.left_active && p.right_active) begin
         if (touching) begin
            r.contact_event = EV_STAY;
         end else begin
            r.contact_event = EV_ENTER;
            if (found) pair_touch_mem[slot] = 1;
         end
      end else if (touching) begin
         r.contact_event = EV_EXIT;
         pair_touch_mem[slot] = 0;
      end else begin
         r.contact_event = EV_NONE;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("error at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return {1'b1, {(COORD_BITS-1){1'b0}}};
         1: return {1'b0, {(COORD_BITS-1){1'b1}}};
         2: return COORD_BITS'($urandom);
         default: return COORD_BITS'($signed($urandom_range(0, 400)) - 200);
      endcase
   endfunction

   // Ids come mostly from a small pool so pairs recur and touch state evolves.
   function automatic req_payload_type rand_check(int id_pool);
      req_payload_type p;
      p.left_id = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, id_pool);
      p.right_id = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, id_pool);
      p.left_x = rand_coord();
      p.left_y = rand_coord();
      p.right_x = rand_coord();
      p.right_y = rand_coord();
      p.left_w = rand_coord();
      p.left_h = rand_coord();
      p.right_w = rand_coord();
      p.right_h = rand_coord();
      if ($urandom_range(0, 1)) begin
         p.right_x = p.left_x + COORD_BITS'($urandom_range(0, 40)) - COORD_BITS'(20);
         p.right_y = p.left_y + COORD_BITS'($urandom_range(0, 40)) - COORD_BITS'(20);
         p.left_w = COORD_BITS'($urandom_range(0, 60));
         p.left_h = COORD_BITS'($urandom_range(0, 60));
      end
      p.left_active = ($urandom_range(0, 4) != 0);
      p.right_active = ($urandom_range(0, 4) != 0);
      return p;
   endfunction

   function automatic req_payload_type box_check(logic [31:0] lid, logic [31:0] rid,
                                                 int dx, int w, bit la, bit ra);
      req_payload_type p;
      p = '0;
      p.left_id = lid;
      p.right_id = rid;
      p.right_x = COORD_BITS'(dx);
      p.left_w = COORD_BITS'(w);
      p.right_w = COORD_BITS'(w);
      p.left_h = COORD_BITS'(16);
      p.right_h = COORD_BITS'(16);
      p.left_active = la;
      p.right_active = ra;
      return p;
   endfunction

   initial begin
      req_payload_type p;
      // Directed: enter, stay, exit, none, inactive sides, edge of touch, negative sizes.
      pending_checks.push_back(box_check(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 16, 1, 1));
      pending_checks.push_back(box_check(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16, 16, 1, 1));
      pending_checks.push_back(box_check(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17, 16, 1, 1));
      pending_checks.push_back(box_check(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17, 16, 1, 1));
      pending_checks.push_back(box_check(0, 0, 0, 16, 1, 0));
      pending_checks.push_back(box_check(0, 0, 0, 16, 1, 1));
      pending_checks.push_back(box_check(0, 0, 0, 16, 0, 1));
      pending_checks.push_back(box_check(0, 1, -16, -16, 1, 1));
      pending_checks.push_back(box_check(1, 0, -17, -16, 1, 1));
      p = '0;
      p.left_x = {1'b1, {(COORD_BITS-1){1'b0}}};
      p.right_x = {1'b0, {(COORD_BITS-1){1'b1}}};
      p.left_w = {1'b0, {(COORD_BITS-1){1'b1}}};
      p.right_w = {1'b0, {(COORD_BITS-1){1'b1}}};
      p.left_y = {1'b1, {(COORD_BITS-1){1'b0}}};
      p.left_h = {1'b1, {(COORD_BITS-1){1'b0}}};
      p.right_h = {1'b1, {(COORD_BITS-1){1'b0}}};
      p.left_active = 1;
      p.right_active = 1;
      p.left_id = 32'h5555_AAAA;
      p.right_id = 32'hAAAA_5555;
      pending_checks.push_back(p);
      p.left_w = '1;
      pending_checks.push_back(p);
      for (int i = 0; i < 700; i++) pending_checks.push_back(rand_check(15));
      // Fill the table past its end, then keep hitting old and new pairs.
      for (int i = 0; i < 300; i++) begin
         p = rand_check(15);
         if (i < 260) begin
            p.left_id = 32'h8000_0000 + i;
            p.right_id = $urandom;
         end
         pending_checks.push_back(p);
      end
   end

   // Driver
   int req_gap = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else begin
         // The accepted beat leaves the queue here, so its head is the next beat.
         if (req_ch.valid && req_ch.ready) begin
            expected_contacts.push_back(track_contact(req_ch.payload));
            void'(pending_checks.pop_front());
         end
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (!(req_ch.valid && !req_ch.ready)) begin
            if (pending_checks.size() > 0 &&
                !(!calm_phase && $urandom_range(0, 7) == 0)) begin
               req_ch.valid <= 1'b1;
               req_ch.payload <= pending_checks[0];
            end else begin
               req_ch.valid <= 1'b0;
               if (!calm_phase) req_gap <= $urandom_range(1, 14);
            end
         end
         if (pending_checks.size() < 100) calm_phase <= 1;
      end
   end

   // Monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_contacts.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               rsp_payload_type want;
               want = expected_contacts.pop_front();
               if (rsp_ch.payload.contact_event !== want.contact_event)
                  report_mismatch("contact_event", rsp_ch.payload.contact_event,
                                  want.contact_event);
               if (rsp_ch.payload.boxes_overlap !== want.boxes_overlap)
                  report_mismatch("boxes_overlap", rsp_ch.payload.boxes_overlap,
                                  want.boxes_overlap);
               if (rsp_ch.payload.table_overflow !== want.table_overflow)
                  report_mismatch("table_overflow", rsp_ch.payload.table_overflow,
                                  want.table_overflow);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            rsp_gap <= $urandom_range(1, 14);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while ((pending_checks.size() > 0 || req_ch.valid || expected_contacts.size() > 0) &&
             cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("aabb_pair_contact_tracker_top: mismatch");
      end else begin
         repeat (SLOTS + 20) @(posedge clock);
         if (mismatch_count == 0)
            $display("aabb_pair_contact_tracker_top: match");
         else
            $display("aabb_pair_contact_tracker_top: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/apct_pkg.sv
rtl/core/apct_if.sv
rtl/core/apct_ram.sv
rtl/core/apct_ctrl.sv
rtl/core/apct_dpath.sv
rtl/core/aabb_pair_contact_tracker_top.sv
tb/sv/testbench.sv
